>>> hdl/upcp_pkg.sv
// ----------------------------------------------------------------------------
// upcp_pkg
// Shared types and constants for the UDP port priority classifier.
// ----------------------------------------------------------------------------
package upcp_pkg;

  // Header limits
  localparam logic [1:0]  MaxVlanTags   = 2'd2;
  localparam logic [2:0]  MaxExtChain   = 3'd6;
  localparam logic [15:0] MaxFrameBytes = 16'd65535;
  localparam logic [15:0] PortReset     = 16'd8081;

  // EtherTypes
  localparam logic [15:0] EthVlanQ  = 16'h8100;
  localparam logic [15:0] EthVlanAd = 16'h88A8;
  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [15:0] EthIpv6   = 16'h86DD;

  // IP protocol numbers
  localparam logic [15:0] ProtoHopByHop = 16'd0;
  localparam logic [15:0] ProtoDestOpts = 16'd60;
  localparam logic [15:0] ProtoRouting  = 16'd43;
  localparam logic [15:0] ProtoMobility = 16'd135;
  localparam logic [15:0] ProtoAuth     = 16'd51;
  localparam logic [15:0] ProtoFragment = 16'd44;
  localparam logic [15:0] ProtoUdp      = 16'd17;

  // Priority codes
  localparam logic [1:0] PrioLow   = 2'd0;
  localparam logic [1:0] PrioEqual = 2'd1;
  localparam logic [1:0] PrioHigh  = 2'd2;

  typedef enum logic [2:0] {
    PhEth   = 3'd0,
    PhVlan  = 3'd1,
    PhIpv4  = 3'd2,
    PhV4Opt = 3'd3,
    PhIpv6  = 3'd4,
    PhExt   = 3'd5,
    PhSkip  = 3'd6,
    PhUdp   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    VerdNone   = 2'd0,
    VerdDrop   = 2'd1,
    VerdAccept = 2'd2
  } verdict_e;

  // Frame verdict handed from parser to the top level
  typedef struct packed {
    logic        accept;
    logic [15:0] udp_port;
  } parse_res_t;

endpackage

>>> hdl/upcp_parser.sv
// ----------------------------------------------------------------------------
// upcp_parser
// Byte-serial header walker: Ethernet, VLAN tags, IPv4 or IPv6 with
// extension chain, then UDP. Produces the verdict for the final byte.
// ----------------------------------------------------------------------------
module upcp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_frame_i,
  output upcp_pkg::parse_res_t  res_o
);
  import upcp_pkg::*;

  logic [15:0] offset_q, offset_d;
  phase_e      phase_q, phase_d;
  logic [10:0] skip_q, skip_d;
  logic [15:0] nxt_type_q, nxt_type_d;
  logic [1:0]  vlan_cnt_q, vlan_cnt_d;
  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic [15:0] shift_q, shift_d;
  logic [15:0] port_q, port_d;
  verdict_e    verd_q, verd_d;

  logic        disp_eth;
  logic        disp_ip6;
  logic        is_ext;
  logic [3:0]  ihl;
  logic [11:0] ext_total;

  assign ihl = shift_q[3:0];

  // Next frame state for one byte
  always_comb begin
    offset_d   = offset_q;
    phase_d    = phase_q;
    skip_d     = skip_q;
    nxt_type_d = nxt_type_q;
    vlan_cnt_d = vlan_cnt_q;
    ext_cnt_d  = ext_cnt_q;
    shift_d    = shift_q;
    port_d     = port_q;
    verd_d     = verd_q;
    disp_eth   = 1'b0;
    disp_ip6   = 1'b0;
    is_ext     = 1'b0;
    ext_total  = 12'd0;

    // oversize frame forces a drop
    if (offset_q == MaxFrameBytes) begin
      verd_d = VerdDrop;
    end else begin
      offset_d = offset_q + 16'd1;
    end

    if (verd_d == VerdNone) begin
      unique case (phase_q)
        PhEth: begin
          skip_d = skip_q + 11'd1;
          if (skip_q == 11'd12) begin
            shift_d = {data_byte_i, 8'h00};
          end else if (skip_q == 11'd13) begin
            nxt_type_d = {shift_q[15:8], data_byte_i};
            disp_eth   = 1'b1;
          end
        end
        PhVlan: begin
          skip_d = skip_q + 11'd1;
          if (skip_q == 11'd2) begin
            shift_d = {data_byte_i, 8'h00};
          end else if (skip_q == 11'd3) begin
            nxt_type_d = {shift_q[15:8], data_byte_i};
            vlan_cnt_d = vlan_cnt_q + 2'd1;
            disp_eth   = 1'b1;
          end
        end
        PhIpv4: begin
          skip_d = skip_q + 11'd1;
          if (skip_q == 11'd0) begin
            shift_d = {12'd0, data_byte_i[3:0]};
          end else if (skip_q == 11'd9) begin
            nxt_type_d = {8'd0, data_byte_i};
          end else if (skip_q == 11'd19) begin
            if (ihl < 4'd5 || nxt_type_q != ProtoUdp) begin
              verd_d = VerdDrop;
            end else if (ihl == 4'd5) begin
              phase_d = PhUdp;
              skip_d  = 11'd0;
            end else begin
              phase_d = PhV4Opt;
              skip_d  = {5'd0, ihl - 4'd5, 2'b00};
            end
          end
        end
        PhV4Opt: begin
          skip_d = skip_q - 11'd1;
          if (skip_d == 11'd0) begin
            phase_d = PhUdp;
          end
        end
        PhIpv6: begin
          skip_d = skip_q + 11'd1;
          if (skip_q == 11'd6) begin
            nxt_type_d = {8'd0, data_byte_i};
          end else if (skip_q == 11'd39) begin
            disp_ip6 = 1'b1;
          end
        end
        PhExt: begin
          skip_d = skip_q + 11'd1;
          if (skip_q == 11'd0) begin
            shift_d = {8'd0, data_byte_i};
          end else begin
            if (nxt_type_q == ProtoAuth) begin
              ext_total = ({4'd0, data_byte_i} + 12'd2) << 2;
            end else if (nxt_type_q == ProtoFragment) begin
              ext_total = 12'd8;
            end else begin
              ext_total = ({4'd0, data_byte_i} + 12'd1) << 3;
            end
            nxt_type_d = {8'd0, shift_q[7:0]};
            ext_cnt_d  = ext_cnt_q + 3'd1;
            phase_d    = PhSkip;
            skip_d     = 11'(ext_total - 12'd2);
          end
        end
        PhSkip: begin
          skip_d = skip_q - 11'd1;
          if (skip_d == 11'd0) begin
            disp_ip6 = 1'b1;
          end
        end
        PhUdp: begin
          skip_d = skip_q + 11'd1;
          if (skip_q == 11'd2) begin
            port_d = {data_byte_i, 8'h00};
          end else if (skip_q == 11'd3) begin
            port_d = {port_q[15:8], data_byte_i};
          end else if (skip_q == 11'd4) begin
            shift_d = {data_byte_i, 8'h00};
          end else if (skip_q == 11'd5) begin
            shift_d = {shift_q[15:8], data_byte_i};
          end else if (skip_q == 11'd7) begin
            verd_d = (shift_q >= 16'd8) ? VerdAccept : VerdDrop;
          end
        end
      endcase
    end

    // EtherType dispatch after the Ethernet header or a tag
    if (disp_eth) begin
      priority if ((nxt_type_d == EthVlanQ || nxt_type_d == EthVlanAd) &&
                   vlan_cnt_d < MaxVlanTags) begin
        phase_d = PhVlan;
        skip_d  = 11'd0;
      end else if (nxt_type_d == EthIpv4) begin
        phase_d = PhIpv4;
        skip_d  = 11'd0;
      end else if (nxt_type_d == EthIpv6) begin
        phase_d = PhIpv6;
        skip_d  = 11'd0;
      end else begin
        verd_d = VerdDrop;
      end
    end

    // IPv6 next-header dispatch
    is_ext = (nxt_type_d == ProtoHopByHop) || (nxt_type_d == ProtoDestOpts) ||
             (nxt_type_d == ProtoRouting)  || (nxt_type_d == ProtoMobility) ||
             (nxt_type_d == ProtoAuth)     || (nxt_type_d == ProtoFragment);
    if (disp_ip6) begin
      priority if (is_ext) begin
        if (ext_cnt_d + 3'd1 < MaxExtChain) begin
          phase_d = PhExt;
          skip_d  = 11'd0;
        end else begin
          verd_d = VerdDrop;
        end
      end else if (nxt_type_d == ProtoUdp) begin
        phase_d = PhUdp;
        skip_d  = 11'd0;
      end else begin
        verd_d = VerdDrop;
      end
    end

    // verdict for the final byte, taken before the frame clear
    res_o.accept   = (verd_d == VerdAccept);
    res_o.udp_port = port_d;

    // final byte returns the frame state to reset
    if (end_of_frame_i) begin
      offset_d   = 16'd0;
      phase_d    = PhEth;
      skip_d     = 11'd0;
      nxt_type_d = 16'd0;
      vlan_cnt_d = 2'd0;
      ext_cnt_d  = 3'd0;
      shift_d    = 16'd0;
      port_d     = 16'd0;
      verd_d     = VerdNone;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= 16'd0;
      phase_q    <= PhEth;
      skip_q     <= 11'd0;
      nxt_type_q <= 16'd0;
      vlan_cnt_q <= 2'd0;
      ext_cnt_q  <= 3'd0;
      shift_q    <= 16'd0;
      port_q     <= 16'd0;
      verd_q     <= VerdNone;
    end else if (byte_valid_i) begin
      offset_q   <= offset_d;
      phase_q    <= phase_d;
      skip_q     <= skip_d;
      nxt_type_q <= nxt_type_d;
      vlan_cnt_q <= vlan_cnt_d;
      ext_cnt_q  <= ext_cnt_d;
      shift_q    <= shift_d;
      port_q     <= port_d;
      verd_q     <= verd_d;
    end
  end

  // tag and extension counters never pass their limits
  a_vlan_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vlan_cnt_q <= MaxVlanTags) else $error("vlan count over limit");
  a_ext_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_cnt_q < MaxExtChain) else $error("extension count over limit");
  // accepted final byte leaves a cleared frame
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_i && end_of_frame_i |=> offset_q == 16'd0 && verd_q == VerdNone)
    else $error("frame state not cleared");

endmodule

>>> hdl/udp_port_priority_classifier_top.sv
// ----------------------------------------------------------------------------
// udp_port_priority_classifier_top
// Classifies Ethernet frames by UDP destination port, one byte per cycle while in_ready_o is high.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one frame byte per word,
//   with end_of_frame_i on the last byte. Every accepted word updates the
//   parser registers in that cycle; a word is taken in every cycle that in_ready_o is high.
//   Only the word marked end_of_frame produces a result: forward_o and
//   priority_res_o (0 below priority_port, 1 equal, 2 above; 0 on drop)
//   appear on out_valid_o in the cycle after that word is accepted.
//   The result sits in an output register. Input words are taken while it
//   is empty or being taken the same cycle; if the receiver holds
//   out_ready_i low, in_ready_o drops until the result is taken.
//   Throughput: one byte per cycle while in_ready_o is high.
//   Config channel (cfg_valid_i/cfg_ready_o) writes priority_port and is
//   always ready; write it only while no frame is in flight.
//   Reset clears all frame state and the output register; priority_port
//   returns to 8081.
// ----------------------------------------------------------------------------
module udp_port_priority_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  // verdict output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        forward_o,
  output logic [1:0]  priority_res_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] priority_port_i
);
  import upcp_pkg::*;

  logic        in_fire;
  logic        cfg_fire;
  parse_res_t  res;
  logic [15:0] prio_port_q;
  logic        out_valid_q, out_valid_d;
  logic        fwd_q, fwd_d;
  logic [1:0]  prio_q, prio_d;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  upcp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (in_fire),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .res_o          (res)
  );

  // Priority register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_port_q <= PortReset;
    end else if (cfg_fire) begin
      prio_port_q <= priority_port_i;
    end
  end

  // Result word: compare port against the priority register
  always_comb begin
    fwd_d  = res.accept;
    prio_d = PrioLow;
    if (res.accept) begin
      priority if (res.udp_port == prio_port_q) begin
        prio_d = PrioEqual;
      end else if (res.udp_port > prio_port_q) begin
        prio_d = PrioHigh;
      end else begin
        prio_d = PrioLow;
      end
    end
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire && end_of_frame_i) begin
      out_valid_d = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && end_of_frame_i) begin
      fwd_q  <= fwd_d;
      prio_q <= prio_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign forward_o      = fwd_q;
  assign priority_res_o = prio_q;

  // a final byte always yields a result next cycle
  a_last_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_frame_i |=> out_valid_o) else $error("missing result");
  // a middle byte never yields a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !end_of_frame_i && !(out_valid_o && !out_ready_i) |=> !out_valid_o)
    else $error("spurious result");
  // dropped frames carry priority zero
  a_drop_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !forward_o |-> priority_res_o == PrioLow)
    else $error("priority on dropped frame");
  // priority code stays in range
  a_prio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> priority_res_o != 2'd3) else $error("bad priority code");
  // configuration write lands in the register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> prio_port_q == $past(priority_port_i))
    else $error("priority port not written");

endmodule
